### design/block_rms_loudness_meter_defines.svh
// Assertion macros for the RMS loudness meter.
`ifndef BLOCK_RMS_LOUDNESS_METER_DEFINES_SVH
`define BLOCK_RMS_LOUDNESS_METER_DEFINES_SVH

// Checked at every rising edge outside reset.
`define BRLM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define BRLM_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/brlm_pkg.sv
`timescale 1ns / 1ps

package brlm_pkg;

	localparam int unsigned MAX_SAMPLES_DEF = 1024;
	localparam int unsigned SQ_W = 31;
	localparam int unsigned LOUD_W = 16;
	localparam int unsigned COUNT_W = 11;
	localparam int unsigned ROOT_IN_W = 32;
	localparam logic [LOUD_W-1:0] LOUD_FULL = 16'h8000;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_STOP = 1'b1;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### design/brlm_in_if.sv
`timescale 1ns / 1ps

interface brlm_in_if;
	logic valid;
	logic ready;
	logic op;
	logic signed [15:0] sample;
	logic last;

	modport source(output valid, output op, output sample, output last, input ready);
	modport sink(input valid, input op, input sample, input last, output ready);
endinterface

### design/brlm_out_if.sv
`timescale 1ns / 1ps

interface brlm_out_if;
	logic valid;
	logic ready;
	logic [brlm_pkg::LOUD_W-1:0] loudness;
	logic [brlm_pkg::COUNT_W-1:0] sample_count;

	modport source(output valid, output loudness, output sample_count, input ready);
	modport sink(input valid, input loudness, input sample_count, output ready);
endinterface

### design/brlm_queue.sv
`timescale 1ns / 1ps

module brlm_queue #(
	parameter int unsigned W = 53
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [W-1:0]        wr_data,
	input  logic                pop,
	output logic [W-1:0]        rd_data,
	output brlm_pkg::q_stat_t   stat
);

	localparam int unsigned DEPTH = 2;
	localparam int unsigned PTR_W = 1;

	logic [W-1:0]       mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [PTR_W:0]     fill_q;

	assign stat.full = (fill_q == (PTR_W+1)'(DEPTH));
	assign stat.empty = (fill_q == '0);
	assign rd_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

### design/brlm_front.sv
`timescale 1ns / 1ps

module brlm_front #(
	parameter int unsigned MAX_SAMPLES = brlm_pkg::MAX_SAMPLES_DEF,
	parameter int unsigned CNT_W = 11,
	parameter int unsigned SUM_W = 41
) (
	input  logic                     clk,
	input  logic                     arst_n,
	brlm_in_if.sink                  audio,
	input  brlm_pkg::q_stat_t        qstat,
	output logic                     push,
	output logic [SUM_W+CNT_W:0]     job
);

	logic                          v_s1;
	logic                          op_s1;
	logic                          last_s1;
	logic signed [15:0]            smp_s1;
	logic                          v_s2;
	logic                          op_s2;
	logic                          last_s2;
	logic [brlm_pkg::SQ_W-1:0]     sq_s2;
	logic [SUM_W-1:0]              sum_q;
	logic [CNT_W-1:0]              cnt_q;

	logic                          take;
	logic                          adv_s1;
	logic                          adv_s2;
	logic                          close_s2;
	logic                          add;
	logic signed [31:0]            prod;
	logic [SUM_W-1:0]              sum_nx;
	logic [CNT_W-1:0]              cnt_nx;
	logic                          stop;

	assign close_s2 = (op_s2 == brlm_pkg::OP_STOP) || last_s2;
	assign adv_s2 = v_s2 && (!close_s2 || !qstat.full);
	assign adv_s1 = v_s1 && (!v_s2 || adv_s2);
	assign audio.ready = !v_s1 || adv_s1;
	assign take = audio.valid && audio.ready;

	assign prod = smp_s1 * smp_s1;

	assign add = (cnt_q < CNT_W'(MAX_SAMPLES));
	assign sum_nx = sum_q + (add ? SUM_W'(sq_s2) : '0);
	assign cnt_nx = cnt_q + CNT_W'(add);
	assign stop = (op_s2 == brlm_pkg::OP_STOP);

	assign push = adv_s2 && close_s2;
	assign job = {stop, stop ? '0 : sum_nx, stop ? '0 : cnt_nx};

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1 <= audio.op;
			last_s1 <= audio.last;
			smp_s1 <= audio.sample;
		end
		if (adv_s1) begin
			op_s2 <= op_s1;
			last_s2 <= last_s1;
			sq_s2 <= prod[brlm_pkg::SQ_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			sum_q <= '0;
			cnt_q <= '0;
		end else begin
			if (take) begin
				v_s1 <= 1'b1;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (adv_s1) begin
				v_s2 <= 1'b1;
			end else if (adv_s2) begin
				v_s2 <= 1'b0;
			end
			if (adv_s2) begin
				if (close_s2) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= sum_nx;
					cnt_q <= cnt_nx;
				end
			end
		end
	end

endmodule

### design/brlm_back.sv
`timescale 1ns / 1ps

module brlm_back #(
	parameter int unsigned CNT_W = 11,
	parameter int unsigned SUM_W = 41
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [SUM_W+CNT_W:0]     job,
	input  brlm_pkg::q_stat_t        qstat,
	output logic                     pop,
	brlm_out_if.source               level
);

	localparam int unsigned STEP_W = $clog2(SUM_W);
	localparam int unsigned RW = brlm_pkg::ROOT_IN_W;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_SQRT = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t                         state_q;
	logic [SUM_W-1:0]               quo_q;
	logic [CNT_W-1:0]               rem_q;
	logic [CNT_W-1:0]               div_q;
	logic [STEP_W-1:0]              step_q;
	logic [RW-1:0]                  v_q;
	logic [RW-1:0]                  root_q;
	logic [RW-1:0]                  bit_q;
	logic [CNT_W-1:0]               cnt_q;
	logic                           out_v_q;
	logic [brlm_pkg::LOUD_W-1:0]    loud_q;
	logic [brlm_pkg::COUNT_W-1:0]   count_q;

	logic                           j_zero;
	logic [SUM_W-1:0]               j_sum;
	logic [CNT_W-1:0]               j_cnt;
	logic [CNT_W:0]                 trial;
	logic [CNT_W:0]                 diff;
	logic                           ge;
	logic [SUM_W-1:0]               quo_nx;
	logic [SUM_W+RW-1:0]            quo_ext;
	logic [RW-1:0]                  root_bit;
	logic                           fits;
	logic [brlm_pkg::LOUD_W+1:0]    loud_w;
	logic [brlm_pkg::LOUD_W-1:0]    loud;
	logic [CNT_W+brlm_pkg::COUNT_W-1:0] cnt_ext;
	logic                           load_out;

	assign j_zero = job[SUM_W+CNT_W];
	assign j_sum = job[SUM_W+CNT_W-1:CNT_W];
	assign j_cnt = job[CNT_W-1:0];

	assign pop = (state_q == S_IDLE) && !qstat.empty;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign diff = trial - {1'b0, div_q};
	assign ge = (trial >= {1'b0, div_q});
	assign quo_nx = {quo_q[SUM_W-2:0], ge};
	assign quo_ext = {{RW{1'b0}}, quo_nx};

	assign root_bit = root_q + bit_q;
	assign fits = (v_q >= root_bit);

	assign loud_w = {root_q[brlm_pkg::LOUD_W:0], 1'b0};
	assign loud = (loud_w > (brlm_pkg::LOUD_W+2)'(brlm_pkg::LOUD_FULL)) ?
		brlm_pkg::LOUD_FULL : loud_w[brlm_pkg::LOUD_W-1:0];
	assign cnt_ext = {{brlm_pkg::COUNT_W{1'b0}}, cnt_q};

	assign load_out = (state_q == S_DONE) && (!out_v_q || level.ready);

	assign level.valid = out_v_q;
	assign level.loudness = loud_q;
	assign level.sample_count = count_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (pop) begin
					cnt_q <= j_zero ? '0 : j_cnt;
					root_q <= '0;
					quo_q <= j_sum;
					rem_q <= '0;
					div_q <= j_cnt;
					step_q <= STEP_W'(SUM_W - 1);
				end
			end
			S_DIV: begin
				rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
				quo_q <= quo_nx;
				step_q <= step_q - 1'b1;
				v_q <= quo_ext[RW-1:0];
				root_q <= '0;
				bit_q <= RW'(1) << (RW - 2);
			end
			S_SQRT: begin
				if (fits) begin
					v_q <= v_q - root_bit;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_DONE: begin
				if (load_out) begin
					loud_q <= loud;
					count_q <= cnt_ext[brlm_pkg::COUNT_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_v_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						state_q <= (j_zero || (j_cnt == '0)) ? S_DONE : S_DIV;
					end
				end
				S_DIV: begin
					if (step_q == '0) begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (bit_q[0]) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (level.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule

### design/block_rms_loudness_meter.sv
`timescale 1ns / 1ps
`include "block_rms_loudness_meter_defines.svh"

// The meter takes one audio word per clock cycle and folds its square into the running
// chunk sums, so words that do not close a chunk never cause a wait. A word that closes a
// chunk, or a stop word, hands the sums to a two-entry queue; for a result with samples,
// the back end runs a one-bit-per-cycle divider over the SUM_W-bit sum, then a square
// root, and it pops a new result from the queue only once it has handed the last one on.
// Input stalls only when a third chunk closes while two results still wait in the queue.
module block_rms_loudness_meter #(
	parameter int unsigned MAX_SAMPLES = brlm_pkg::MAX_SAMPLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	brlm_in_if.sink     audio,
	brlm_out_if.source  level
);

	localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned SUM_W = CNT_W + brlm_pkg::SQ_W - 1;
	localparam int unsigned JOB_W = SUM_W + CNT_W + 1;

	logic                 push;
	logic                 pop;
	logic [JOB_W-1:0]     job_in;
	logic [JOB_W-1:0]     job_out;
	brlm_pkg::q_stat_t    qstat;

	brlm_front #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.CNT_W(CNT_W),
		.SUM_W(SUM_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.audio(audio),
		.qstat(qstat),
		.push(push),
		.job(job_in)
	);

	brlm_queue #(
		.W(JOB_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_data(job_in),
		.pop(pop),
		.rd_data(job_out),
		.stat(qstat)
	);

	brlm_back #(
		.CNT_W(CNT_W),
		.SUM_W(SUM_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job(job_out),
		.qstat(qstat),
		.pop(pop),
		.level(level)
	);

	`BRLM_ASSERT(a_queue_no_overflow, push |-> !qstat.full, "Chunk result pushed into a full queue.")
	`BRLM_ASSERT(a_queue_no_underflow, pop |-> !qstat.empty, "Back end popped an empty queue.")
	`BRLM_ASSERT(a_loudness_range, level.valid |-> (level.loudness <= brlm_pkg::LOUD_FULL), "Loudness above full scale.")
	`BRLM_ASSERT_RST(a_reset_quiet, !arst_n |-> !level.valid, "Output word valid during reset.")

endmodule
